>>> sv/mbt_pkg.sv
// Package for the multiset bag table: sizes, codes and controller/datapath structs.
package mbt_pkg;

  localparam int DEPTH     = 16;
  localparam int WIDTH     = 32;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int ACTION_W  = 2;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;
  localparam int LIMIT_W   = 5;
  localparam int CMP_W     = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD      = 2'd0,
    ACT_CONTAINS = 2'd1,
    ACT_REMOVE   = 2'd2
  } mbt_action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOMATCH = 2'd2
  } mbt_status_e;

  // controller -> datapath
  typedef struct packed {
    logic        req_ld;
    logic        add_wr;
    logic        ptr_clr;
    logic        ptr_inc;
    logic        rd_next;
    logic        shift_wr;
    logic        cnt_dec;
    logic        res_set;
    mbt_status_e res_status;
    logic        res_found;
    logic        out_ld;
  } mbt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic                cnt_zero;
    logic                can_add;
    logic                hit;
    logic                ptr_last;
    logic                out_free;
  } mbt_sts_t;

endpackage

>>> sv/mbt_if.sv
// Channel interfaces: request items, result items and the limit register write.
interface mbt_in_if;
  import mbt_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [VALUE_W-1:0]  value;
  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

interface mbt_out_if;
  import mbt_pkg::*;
  logic                valid;
  logic                ready;
  logic                found;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  entry_count;
  logic                is_empty;
  modport source (output valid, found, status, entry_count, is_empty, input ready);
  modport sink   (input valid, found, status, entry_count, is_empty, output ready);
endinterface

interface mbt_cfg_if;
  import mbt_pkg::*;
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> sv/mbt_ctrl.sv
// Controller state machine of the bag table: sequences add, search and gap closing.
module mbt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mbt_pkg::mbt_sts_t sts_i,
  output mbt_pkg::mbt_cmd_t cmd_o
);
  import mbt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_SHIFT,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    cmd_o.res_status = ST_DONE;
    state_d    = state_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.req_ld = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.res_set = 1'b1;
        state_d       = S_DONE;
        case (mbt_action_e'(sts_i.act))
          ACT_ADD: begin
            cmd_o.add_wr     = sts_i.can_add;
            cmd_o.res_status = sts_i.can_add ? ST_DONE : ST_FULL;
          end
          ACT_CONTAINS, ACT_REMOVE: begin
            cmd_o.ptr_clr = 1'b1;
            if (sts_i.cnt_zero) begin
              cmd_o.res_status = (mbt_action_e'(sts_i.act) == ACT_REMOVE) ? ST_NOMATCH
                                                                         : ST_DONE;
            end else begin
              cmd_o.res_set = 1'b0;
              state_d       = S_SEARCH;
            end
          end
          default: ;
        endcase
      end
      S_SEARCH: begin
        if (sts_i.hit) begin
          cmd_o.res_set   = 1'b1;
          cmd_o.res_found = 1'b1;
          state_d = (mbt_action_e'(sts_i.act) == ACT_REMOVE) ? S_SHIFT : S_DONE;
        end else if (sts_i.ptr_last) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = (mbt_action_e'(sts_i.act) == ACT_REMOVE) ? ST_NOMATCH : ST_DONE;
          state_d          = S_DONE;
        end else begin
          cmd_o.ptr_inc = 1'b1;
        end
      end
      S_SHIFT: begin
        // ptr sits on the hole; pull the next entry down until the tail
        cmd_o.rd_next = 1'b1;
        if (sts_i.ptr_last) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.shift_wr = 1'b1;
          cmd_o.ptr_inc  = 1'b1;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/mbt_dp.sv
// Datapath of the bag table: entry store, count, limit, walk pointer and result register.
module mbt_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mbt_pkg::mbt_cmd_t            cmd_i,
  output mbt_pkg::mbt_sts_t            sts_o,
  input  logic [mbt_pkg::ACTION_W-1:0] action_i,
  input  logic [mbt_pkg::VALUE_W-1:0]  value_i,
  input  logic                         cfg_wr_i,
  input  logic [mbt_pkg::LIMIT_W-1:0]  cfg_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         out_found_o,
  output logic [mbt_pkg::STATUS_W-1:0] out_status_o,
  output logic [mbt_pkg::COUNT_W-1:0]  out_count_o,
  output logic                         out_empty_o
);
  import mbt_pkg::*;

  logic [WIDTH-1:0]    entries_q [DEPTH];
  logic [CNT_W-1:0]    cnt_q;
  logic [LIMIT_W-1:0]  limit_q;
  logic [IDX_W-1:0]    ptr_q;
  logic [ACTION_W-1:0] act_q;
  logic [WIDTH-1:0]    val_q;
  logic                res_found_q;
  mbt_status_e         res_status_q;
  logic                out_valid_q;
  logic                out_found_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [COUNT_W-1:0]  out_count_q;
  logic                out_empty_q;

  logic [CNT_W-1:0]    ptr_plus1;
  logic [IDX_W-1:0]    rd_idx;
  logic [WIDTH-1:0]    rd_data;

  assign ptr_plus1 = CNT_W'(ptr_q) + CNT_W'(1);
  assign rd_idx    = cmd_i.rd_next ? ptr_plus1[IDX_W-1:0] : ptr_q;
  assign rd_data   = entries_q[rd_idx];

  assign sts_o.act      = act_q;
  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.can_add  = (CMP_W'(cnt_q) < CMP_W'(limit_q)) && (cnt_q < CNT_W'(DEPTH));
  assign sts_o.hit      = (rd_data == val_q);
  assign sts_o.ptr_last = (ptr_plus1 >= cnt_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // entry store, request payload and result registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_ld) begin
      act_q <= action_i;
      val_q <= value_i[WIDTH-1:0];
    end
    if (cmd_i.add_wr) begin
      entries_q[cnt_q[IDX_W-1:0]] <= val_q;
    end
    if (cmd_i.shift_wr) begin
      entries_q[ptr_q] <= rd_data;
    end
    if (cmd_i.res_set) begin
      res_found_q  <= cmd_i.res_found;
      res_status_q <= cmd_i.res_status;
    end
    if (cmd_i.out_ld) begin
      out_found_q  <= res_found_q;
      out_status_q <= res_status_q;
      out_count_q  <= COUNT_W'(cnt_q);
      out_empty_q  <= (cnt_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      limit_q     <= LIMIT_W'(16);
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr_i) begin
        limit_q <= cfg_data_i;
      end
      if (cmd_i.add_wr) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_plus1[IDX_W-1:0];
      end
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_found_o  = out_found_q;
  assign out_status_o = out_status_q;
  assign out_count_o  = out_count_q;
  assign out_empty_o  = out_empty_q;

endmodule

>>> sv/multiset_bag_table_top.sv
// Top level of the multiset bag table.
// Add, undefined action or empty-bag search go straight to the result; contains and remove
// walk the bag comparing one entry per cycle, and a remove hit then pulls each later entry
// down in turn to close the gap.
// One request in flight; the next is accepted the cycle after its result is registered.
// Reset empties the bag, limit 16.
module multiset_bag_table_top (
  input  logic    clk_i,
  input  logic    rst_ni,
  mbt_in_if.sink  in_i,
  mbt_out_if.source out_o,
  mbt_cfg_if.sink cfg_i
);
  import mbt_pkg::*;

  mbt_cmd_t cmd;
  mbt_sts_t sts;

  assign cfg_i.ready = 1'b1;

  mbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mbt_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .action_i     (in_i.action),
    .value_i      (in_i.value),
    .cfg_wr_i     (cfg_i.valid),
    .cfg_data_i   (cfg_i.data),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_found_o  (out_o.found),
    .out_status_o (out_o.status),
    .out_count_o  (out_o.entry_count),
    .out_empty_o  (out_o.is_empty)
  );

endmodule

>>> sv/mbt_checker.sv
// Port-level checker for the bag table and its bind to the top level.
module mbt_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_found,
  input logic [mbt_pkg::STATUS_W-1:0] out_status,
  input logic [mbt_pkg::COUNT_W-1:0]  out_count,
  input logic                         out_empty
);
  import mbt_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_count) && $stable(out_status))
    else $error("result item changed while stalled");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_empty == (out_count == '0)))
    else $error("empty flag disagrees with count");

  // a remove hit may leave the bag empty, so only the status is tied to found
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_found |-> out_status == ST_DONE)
    else $error("found with error status");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while one is in flight");

endmodule

bind multiset_bag_table_top mbt_checker u_mbt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_i.valid),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_found  (out_o.found),
  .out_status (out_o.status),
  .out_count  (out_o.entry_count),
  .out_empty  (out_o.is_empty)
);

>>> tb/sv/testbench.sv
// Self-checking testbench for the multiset bag table: directed and random requests.
`timescale 1ns / 100ps

module testbench;
  import mbt_pkg::*;

  // action code outside the defined set; the block must ignore it
  localparam logic [ACTION_W-1:0] ACT_UNDEF = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS = 40;
  localparam int TAIL_CYCLES = 2 * DEPTH + 8;

  typedef struct packed {
    logic               found;
    mbt_status_e        status;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
  } bag_result_t;

  logic clk;
  logic rst_n;

  mbt_in_if  req_ch ();
  mbt_out_if res_ch ();
  mbt_cfg_if cfg_ch ();

  multiset_bag_table_top uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_ch),
    .out_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  // predicted bag contents, oldest first, and the limit register
  logic [VALUE_W-1:0] held_values[$];
  logic [LIMIT_W-1:0] limit_q;
  bag_result_t        pending_results[$];
  logic [VALUE_W-1:0] value_pool[8];

  int  mismatch_count;
  int  quiet_cycles;
  bit  steady;
  bit  req_raised;
  bag_result_t exp_r;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bag_result_t bag_predict(input logic [ACTION_W-1:0] act,
                                              input logic [VALUE_W-1:0] val);
    bag_result_t r;
    int eff;
    int pos;
    r = '0;
    r.status = ST_DONE;
    eff = (limit_q > DEPTH) ? DEPTH : int'(limit_q);
    pos = -1;
    for (int i = 0; i < held_values.size(); i++) begin
      if (pos < 0 && held_values[i] == val) pos = i;
    end
    case (act)
      ACT_ADD: begin
        if (held_values.size() < eff && held_values.size() < DEPTH) held_values.push_back(val);
        else r.status = ST_FULL;
      end
      ACT_CONTAINS: r.found = (pos >= 0);
      ACT_REMOVE: begin
        if (pos >= 0) begin
          r.found = 1'b1;
          held_values.delete(pos);
        end else begin
          r.status = ST_NOMATCH;
        end
      end
      default: ;
    endcase
    r.entry_count = COUNT_W'(held_values.size());
    r.is_empty = (held_values.size() == 0);
    return r;
  endfunction

  task automatic lower_request();
    if (req_raised) begin
      req_ch.valid <= 1'b0;
      req_raised = 1'b0;
    end
  endtask

  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val);
    int gap;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(99) < 31) gap++;
    end
    if (gap > 0) begin
      lower_request();
      repeat (gap) @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.action <= act;
    req_ch.value  <= val;
    req_raised = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(bag_predict(act, val));
  endtask

  task automatic drain_results();
    lower_request();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] lim);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= lim;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    limit_q = lim;
    @(posedge clk);
  endtask

  // mostly values already held or from a small pool, so hits and duplicates are common
  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 35 && held_values.size() != 0)
      return held_values[$urandom_range(held_values.size() - 1)];
    if (r < 75) return value_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  task automatic run_traffic(input int n_items, input int add_pct);
    int r;
    logic [ACTION_W-1:0] act;
    value_pool[0] = '0;
    value_pool[1] = '1;
    for (int i = 2; i < 8; i++) value_pool[i] = $urandom;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(99);
      if (r < 2) act = ACT_UNDEF;
      else if (r < add_pct) act = ACT_ADD;
      else if (r < add_pct + (100 - add_pct) / 3) act = ACT_CONTAINS;
      else act = ACT_REMOVE;
      send_item(act, pick_value());
    end
  endtask

  task automatic test_empty_bag();
    send_item(ACT_REMOVE, 32'd7);
    send_item(ACT_CONTAINS, '0);
    send_item(ACT_UNDEF, '1);
  endtask

  task automatic test_duplicates();
    write_limit(5'd16);
    send_item(ACT_ADD, '0);
    send_item(ACT_ADD, '1);
    send_item(ACT_ADD, 32'd9);
    send_item(ACT_ADD, 32'd9);
    send_item(ACT_ADD, 32'h5a5a_5a5a);
    send_item(ACT_CONTAINS, '1);
    send_item(ACT_CONTAINS, 32'd1);
    // only the first 9 goes, the second must still be found
    send_item(ACT_REMOVE, 32'd9);
    send_item(ACT_CONTAINS, 32'd9);
    send_item(ACT_REMOVE, '0);
  endtask

  task automatic test_limit_edges();
    // limit below the count: held entries stay, adds refused until removes bring the count under it
    write_limit(5'd2);
    send_item(ACT_ADD, 32'd3);
    send_item(ACT_REMOVE, 32'd9);
    send_item(ACT_ADD, 32'd3);
    send_item(ACT_REMOVE, '1);
    send_item(ACT_ADD, 32'd3);
    write_limit(5'd0);
    send_item(ACT_ADD, 32'd4);
    // above DEPTH saturates
    write_limit(5'd31);
    send_item(ACT_ADD, 32'd1);
  endtask

  task automatic test_random_traffic();
    logic [LIMIT_W-1:0] lim;
    int add_pct;
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: lim = 5'd1;
        1: lim = 5'd16;
        2: lim = 5'd31;
        3: lim = 5'd0;
        4: lim = LIMIT_W'($urandom_range(17, 31));
        default: lim = LIMIT_W'($urandom_range(2, 15));
      endcase
      add_pct = (p == 1 || p == 2) ? 65 : $urandom_range(35, 65);
      write_limit(lim);
      run_traffic(190, add_pct);
    end
  endtask

  task automatic test_back_to_back();
    write_limit(LIMIT_W'($urandom_range(1, 16)));
    steady = 1'b1;
    run_traffic(200, 55);
    drain_results();
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    res_ch.ready <= steady || ($urandom_range(99) >= 31);
  end

  task automatic report_mismatch(input string what, input int e, input int a);
    if (mismatch_count < MAX_REPORTS)
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, e, a);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("%0t: unexpected result: expected none, actual found %0d status %0d count %0d",
                   $time, res_ch.found, res_ch.status, res_ch.entry_count);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (res_ch.found !== exp_r.found)
          report_mismatch("found", int'(exp_r.found), int'(res_ch.found));
        if (res_ch.status !== exp_r.status)
          report_mismatch("status", int'(exp_r.status), int'(res_ch.status));
        if (res_ch.entry_count !== exp_r.entry_count)
          report_mismatch("entry_count", int'(exp_r.entry_count), int'(res_ch.entry_count));
        if (res_ch.is_empty !== exp_r.is_empty)
          report_mismatch("is_empty", int'(exp_r.is_empty), int'(res_ch.is_empty));
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    mismatch_count = 0;
    quiet_cycles = 0;
    steady = 1'b0;
    req_raised = 1'b0;
    limit_q = 5'd16;
    rst_n <= 1'b0;
    req_ch.valid  <= 1'b0;
    req_ch.action <= ACT_ADD;
    req_ch.value  <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.data   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_bag();
    test_duplicates();
    test_limit_edges();
    test_random_traffic();
    test_back_to_back();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
